### hw/rtl/rgb2hsl_pkg.sv
// Package: shared types and constants for the RGB to HSL pixel converter.
`timescale 1ns / 1ps
package rgb2hsl_pkg;

  localparam int unsigned HueSector   = 3840;
  localparam int unsigned HueFullTurn = 23040;
  localparam int unsigned FracOne     = 65535;

  // Inverse tables: round-up reciprocals, exact for the numerator ranges used.
  // entry d = ceil(2^32 / d) for d in 1..255, entry 0 unused
  typedef logic [255:0][32:0] recip_tab_t;

  function automatic recip_tab_t recip_tab();
    recip_tab_t t;
    t[0] = '0;
    for (int d = 1; d < 256; d++) begin
      t[d] = 33'((64'h1_0000_0000 + 64'(d) - 64'd1) / 64'(d));
    end
    return t;
  endfunction

  localparam recip_tab_t RecipTab = recip_tab();

  typedef struct packed {
    logic [7:0]  c;       // max - min
    logic [22:0] hnum;    // 3840 * hue numerator, up to 3840*6*255
    logic [7:0]  sden;    // saturation divisor, 0 means sat 0
    logic [15:0] light;
    logic [15:0] alpha;
  } rgb2hsl_s1_t;

  typedef struct packed {
    logic [16:0] hq;      // hue quotient before wrap
    logic [16:0] sq;      // saturation quotient before clamp
    logic [15:0] light;
    logic [15:0] alpha;
  } rgb2hsl_s2_t;

endpackage

### hw/rtl/rgb2hsl_front.sv
// Front stage: max/min, hue numerator, divisors, lightness and alpha.
`timescale 1ns / 1ps
module rgb2hsl_front (
  input  logic [7:0]               red_i,
  input  logic [7:0]               green_i,
  input  logic [7:0]               blue_i,
  input  logic [7:0]               alpha_i,
  output rgb2hsl_pkg::rgb2hsl_s1_t res_o
);
  import rgb2hsl_pkg::*;

  logic [7:0] mx, mn, c;
  logic [8:0] sum;
  logic [10:0] num;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    c   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    if (mx == red_i) begin
      if (green_i >= blue_i) num = 11'(green_i - blue_i);
      else num = 11'(6 * c) - 11'(blue_i - green_i);
    end else if (mx == green_i) begin
      num = 11'(blue_i) + 11'(2 * c) - 11'(red_i);
    end else begin
      num = 11'(red_i) + 11'(4 * c) - 11'(green_i);
    end
    if (c == 8'd0) num = '0;
    res_o.c     = c;
    res_o.hnum  = 23'(num);
    // min(sum, 510-sum) never exceeds 255
    if (c == 8'd0) res_o.sden = '0;
    else if (sum <= 9'd255) res_o.sden = sum[7:0];
    else res_o.sden = 8'(9'd510 - sum);
    res_o.light = 16'((18'd257 * 18'(sum)) >> 1);
    res_o.alpha = {alpha_i, alpha_i};
  end
endmodule

### hw/rtl/rgb2hsl_div.sv
// Divide stage: reciprocal multiplies for hue and saturation.
`timescale 1ns / 1ps
module rgb2hsl_div (
  input  rgb2hsl_pkg::rgb2hsl_s1_t a_i,
  output rgb2hsl_pkg::rgb2hsl_s2_t res_o
);
  import rgb2hsl_pkg::*;

  logic [32:0] rh, rs;
  logic [56:0] ph, ps;   // numerators < 2^24, reciprocals < 2^33
  logic [23:0] snum;

  always_comb begin
    // 65535 * c as a shift and subtract
    snum = {a_i.c, 16'd0} - 24'(a_i.c);
    rh = RecipTab[a_i.c];
    rs = RecipTab[a_i.sden];
    ph = 57'(a_i.hnum) * 57'(rh);
    ps = 57'(snum) * 57'(rs);
    res_o.hq    = 17'(ph >> 32);
    res_o.sq    = (a_i.sden == 8'd0) ? 17'd0 : 17'(ps >> 32);
    res_o.light = a_i.light;
    res_o.alpha = a_i.alpha;
  end
endmodule

### hw/rtl/rgb_to_hsl_pixel.sv
// Top level: pipelined RGBA to HSL pixel converter with stream handshakes.
//
//  channel | dir | fields (tdata, lsb first)
//  s_axis  | in  | red[7:0] green[15:8] blue[23:16] alpha[31:24]
//  m_axis  | out | hue[14:0] sat[30:15] light[46:31] alpha_frac[62:47] pad[63]
//
// One word per clock while the output is not stalled. The pipeline registers
// are front compute, hue numerator scaling, reciprocal multiply, and wrap and clamp into the output register.
// Reset clears only valid bits. A stall on the output freezes every stage
// at once (pipeline enable is !out_valid || tready); nothing is dropped.
`timescale 1ns / 1ps
module rgb_to_hsl_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // red, green, blue, alpha
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // hue(15), saturation, lightness, alpha_frac, 0
);
  import rgb2hsl_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  rgb2hsl_s1_t s1_d, s1_q, s2_q;
  rgb2hsl_s2_t s3_d, s3_q;
  logic [63:0] out_d, out_q;

  // whole pipe moves when the last stage is free or being taken
  assign adv = !v4_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  rgb2hsl_front u_front (
    .red_i  (s_axis_tdata_i[7:0]),
    .green_i(s_axis_tdata_i[15:8]),
    .blue_i (s_axis_tdata_i[23:16]),
    .alpha_i(s_axis_tdata_i[31:24]),
    .res_o  (s1_d)
  );

  // stage 2: scale hue numerator by the sector width
  rgb2hsl_s1_t s2_d;
  always_comb begin
    s2_d = s1_q;
    s2_d.hnum = 23'(32'(s1_q.hnum[10:0]) * HueSector);
  end

  rgb2hsl_div u_div (
    .a_i  (s2_q),
    .res_o(s3_d)
  );

  always_comb begin
    logic [16:0] h;
    h = s3_q.hq;
    if (h >= 17'(HueFullTurn)) h = h - 17'(HueFullTurn);
    out_d[14:0]  = h[14:0];
    out_d[30:15] = (s3_q.sq > 17'(FracOne)) ? 16'hFFFF : s3_q.sq[15:0];
    out_d[46:31] = s3_q.light;
    out_d[62:47] = s3_q.alpha;
    out_d[63]    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = out_q;
endmodule

### tb/testbench.sv
// Testbench for the RGBA to HSL pixel converter: directed and random pixels, scoreboard check.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] light;
    logic [15:0] alpha_frac;
  } hsl_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;

  hsl_t        hsl_expected_q[$];
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;   // no idling on either side while set

  localparam int CycleLimit = 200000;

  rgb_to_hsl_pixel dut (.*);

  always #5 clk_i = ~clk_i;

  // Exact rational HSL, truncated.
  function automatic hsl_t hsl_of(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [7:0] a);
    int   mx, mn, c, sum, d, num, h, s;
    hsl_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    sum = mx + mn;
    h = 0;
    if (c != 0) begin
      if (mx == r) num = (g >= b) ? g - b : 6 * c - (b - g);
      else if (mx == g) num = b + 2 * c - r;
      else num = r + 4 * c - g;
      h = (3840 * num) / c;
      if (h >= 23040) h -= 23040;
    end
    d = (sum <= 255) ? sum : 510 - sum;
    s = (d == 0 || c == 0) ? 0 : (65535 * c) / d;
    if (s > 65535) s = 65535;
    res.hue = h[14:0];
    res.sat = s[15:0];
    res.light = 16'((257 * sum) / 2);
    res.alpha_frac = 16'(a * 257);
    return res;
  endfunction

  // Ready is sampled mid-cycle, where it is stable up to the next rising edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {a, b, g, r};
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    hsl_expected_q.push_back(hsl_of(r, g, b, a));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (hsl_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 28);
  end

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin
    hsl_t exp_w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (hsl_expected_q.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        exp_w = hsl_expected_q.pop_front();
        if (m_axis_tdata_o[14:0] !== exp_w.hue) begin
          $error("hue exp %0d got %0d", exp_w.hue, m_axis_tdata_o[14:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[30:15] !== exp_w.sat) begin
          $error("saturation exp %0d got %0d", exp_w.sat, m_axis_tdata_o[30:15]);
          err_cnt++;
        end
        if (m_axis_tdata_o[46:31] !== exp_w.light) begin
          $error("lightness exp %0d got %0d", exp_w.light, m_axis_tdata_o[46:31]);
          err_cnt++;
        end
        if (m_axis_tdata_o[62:47] !== exp_w.alpha_frac) begin
          $error("alpha_frac exp %0d got %0d", exp_w.alpha_frac, m_axis_tdata_o[62:47]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Grey, black, white, extremes, each sector, ties and hue wrap.
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd0, 8'd1, 8'd128);    // red max, blue > green: hue just below 360
    send_pixel(8'd255, 8'd255, 8'd0, 8'd0);    // red/green tie
    send_pixel(8'd0, 8'd255, 8'd255, 8'd0);    // green/blue tie
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0);    // red/blue tie
    send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd127, 8'd0);
    send_pixel(8'd127, 8'd128, 8'd128, 8'd0);
    send_pixel(8'd10, 8'd200, 8'd90, 8'd170);
    send_pixel(8'd90, 8'd10, 8'd200, 8'd85);
    send_pixel(8'd170, 8'd85, 8'd85, 8'd255);
  endtask

  task automatic test_random(int n);
    logic [7:0] r, g, b;
    repeat (n) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(5))
        0: g = r;
        1: b = ($urandom_range(1)) ? r : g;
        2: begin g = r; b = r; end
        default: ;
      endcase
      send_pixel(r, g, b, 8'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();                     // sender holds off until all results are in
    test_random(250);
    calm = 1'b1;                 // back-to-back stretch
    test_random(100);
    calm = 1'b0;
    test_random(250);
    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
